// ===== rtl/wah_pkg.sv =====
// types, constants and round functions for the word array hash
// depends on nothing; imported by word_array_hash, its checker and its bench
`timescale 1ns / 1ps

package wah_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned InW    = 80;  // data_word, word_count, start_value
  localparam int unsigned MaxWords = 65535;

  localparam logic [WordW-1:0] HashInit = 32'hdeadbeef;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
  } abc_t;

  // message tail waiting for the final rounds
  typedef struct packed {
    logic [WordW-1:0] w0;
    logic [WordW-1:0] w1;
    logic [WordW-1:0] w2;
    logic             has_mix;
    logic             bypass;
  } tail_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x, input int k);
    rotl = (x << k) | (x >> (WordW - k));
  endfunction

  // mix rounds one to three
  function automatic abc_t mix_lo(input abc_t s);
    abc_t r;
    r = s;
    r.a = r.a - r.c; r.a = r.a ^ rotl(r.c, 4);  r.c = r.c + r.b;
    r.b = r.b - r.a; r.b = r.b ^ rotl(r.a, 6);  r.a = r.a + r.c;
    r.c = r.c - r.b; r.c = r.c ^ rotl(r.b, 8);  r.b = r.b + r.a;
    mix_lo = r;
  endfunction

  // mix rounds four to six
  function automatic abc_t mix_hi(input abc_t s);
    abc_t r;
    r = s;
    r.a = r.a - r.c; r.a = r.a ^ rotl(r.c, 16); r.c = r.c + r.b;
    r.b = r.b - r.a; r.b = r.b ^ rotl(r.a, 19); r.a = r.a + r.c;
    r.c = r.c - r.b; r.c = r.c ^ rotl(r.b, 4);  r.b = r.b + r.a;
    mix_hi = r;
  endfunction

  function automatic abc_t fin_12(input abc_t s);
    abc_t r;
    r = s;
    r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 14);
    r.a = r.a ^ r.c; r.a = r.a - rotl(r.c, 11);
    fin_12 = r;
  endfunction

  function automatic abc_t fin_34(input abc_t s);
    abc_t r;
    r = s;
    r.b = r.b ^ r.a; r.b = r.b - rotl(r.a, 25);
    r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 16);
    fin_34 = r;
  endfunction

  function automatic abc_t fin_567(input abc_t s);
    abc_t r;
    r = s;
    r.a = r.a ^ r.c; r.a = r.a - rotl(r.c, 4);
    r.b = r.b ^ r.a; r.b = r.b - rotl(r.a, 14);
    r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 24);
    fin_567 = r;
  endfunction

endpackage

// ===== rtl/word_array_hash.sv =====
// word_array_hash: streaming lookup3 word hash
// the input stream carries one message word per beat; a result word is the hash
// one hash word leaves on the master side for each message, in message order
// a beat taken while no message runs starts one: its word_count and start_value
// set the length and seed, its data_word is the first message word
// a zero-length start gives the initial c, with no rounds, and its data word is dropped
// throughput: one word per cycle while messages run and s_tready is high; every third
// word that does not end a message issues a three-stage mix pipeline, whose result
// the next triple picks up from a register; a message tail that comes while its last mix
// is still in flight, or while the final pipeline is stalled, parks in a one-entry holding
// register and s_tready drops until it moves on, once its mix has left the first two
// mix stages and the final pipeline can take it
// the last word's sum is registered in f1, then the final rounds run in f2, f3 and the
// output register that drives m_tvalid, after any wait in the holding register
// a stalled receiver holds the output register and the final pipeline; words
// keep being taken until a tail finds no room
// reset (rst, synchronous) empties all pipelines and leaves the block idle
`timescale 1ns / 1ps

module word_array_hash
  import wah_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [InW-1:0]   s_tdata,   // data_word[31:0], word_count[47:32], start_value[79:48]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [WordW-1:0] m_tdata    // hash_value[31:0]
);

  logic [WordW-1:0]  data_word;
  logic [CountW-1:0] word_count;
  logic [WordW-1:0]  start_value;

  assign data_word   = s_tdata[31:0];
  assign word_count  = s_tdata[47:32];
  assign start_value = s_tdata[79:48];

  // message state
  logic [CountW-1:0] words_left;
  logic [1:0]        slot;
  logic              mixed;
  logic [WordW-1:0]  init_val;
  logic [WordW-1:0]  wbuf0;
  logic [WordW-1:0]  wbuf1;

  // mix pipeline
  logic  s1_v, s2_v;
  abc_t  s1, s2, s3;

  // holding register for a tail
  logic  tail_v;
  tail_t tail;

  // final pipeline
  logic  f1_v, f2_v, f3_v, out_v;
  logic  f1_byp, f2_byp, f3_byp;
  abc_t  f1, f2, f3, out_r;
  logic  f1_rdy, f2_rdy, f3_rdy, out_rdy;

  logic              acc;
  logic              starting;
  logic [CountW-1:0] count;
  logic [WordW-1:0]  init_now;
  logic [WordW-1:0]  base_init;
  logic [CountW-1:0] left;
  logic [1:0]        slot_cur;
  logic              has_mix;
  logic              ends;
  logic              issue_mix;
  tail_t             tail_now;
  logic              dep_now, dep_tail;
  logic              launch_in, launch_tail, launch;
  abc_t              base, launch_abc;
  logic              launch_byp;
  abc_t              mix_in;

  assign s_tready = !tail_v;
  assign acc      = s_tvalid && s_tready;

  assign out_rdy = !out_v || m_tready;
  assign f3_rdy  = !f3_v || out_rdy;
  assign f2_rdy  = !f2_v || f3_rdy;
  assign f1_rdy  = !f1_v || f2_rdy;

  always_comb begin
    starting  = (words_left == '0);
    count     = (32'(word_count) > MaxWords) ? CountW'(MaxWords) : word_count;
    init_now  = HashInit + {14'd0, count, 2'b00} + start_value;
    base_init = starting ? init_now : init_val;
    left      = starting ? count : words_left;
    slot_cur  = starting ? 2'd0 : slot;
    has_mix   = starting ? 1'b0 : mixed;
    ends      = (left <= CountW'(1));

    tail_now = '0;
    if (left == '0) begin
      tail_now.bypass = 1'b1;
    end else begin
      tail_now.has_mix = has_mix;
      case (slot_cur)
        2'd0: begin
          tail_now.w0 = data_word;
        end
        2'd1: begin
          tail_now.w0 = wbuf0;
          tail_now.w1 = data_word;
        end
        default: begin
          tail_now.w0 = wbuf0;
          tail_now.w1 = wbuf1;
          tail_now.w2 = data_word;
        end
      endcase
    end

    issue_mix = acc && !ends && (slot_cur >= 2'd2);

    // a mixed state is ready once it has left the first two mix stages
    dep_now  = !tail_now.has_mix || (!s1_v && !s2_v);
    dep_tail = !tail.has_mix || (!s1_v && !s2_v);

    launch_tail = tail_v && dep_tail && f1_rdy;
    launch_in   = acc && ends && dep_now && f1_rdy;
    launch      = launch_tail || launch_in;

    if (launch_tail) begin
      base       = tail.has_mix ? s3 : abc_t'{a: init_val, b: init_val, c: init_val};
      launch_abc = '{a: base.a + tail.w0, b: base.b + tail.w1, c: base.c + tail.w2};
      launch_byp = tail.bypass;
    end else begin
      base       = tail_now.has_mix ? s3 : abc_t'{a: base_init, b: base_init, c: base_init};
      launch_abc = '{a: base.a + tail_now.w0, b: base.b + tail_now.w1,
                     c: base.c + tail_now.w2};
      launch_byp = tail_now.bypass;
    end

    mix_in = has_mix ? s3 : abc_t'{a: base_init, b: base_init, c: base_init};
    mix_in = '{a: mix_in.a + wbuf0, b: mix_in.b + wbuf1, c: mix_in.c + data_word};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_left <= '0;
      slot       <= '0;
      mixed      <= 1'b0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      tail_v     <= 1'b0;
      f1_v       <= 1'b0;
      f2_v       <= 1'b0;
      f3_v       <= 1'b0;
      out_v      <= 1'b0;
    end else begin
      if (acc) begin
        if (ends) begin
          words_left <= '0;
          slot       <= '0;
          mixed      <= 1'b0;
        end else begin
          words_left <= left - CountW'(1);
          if (slot_cur >= 2'd2) begin
            slot  <= '0;
            mixed <= 1'b1;
          end else begin
            slot  <= slot_cur + 2'd1;
            mixed <= has_mix;
          end
        end
      end

      s1_v <= issue_mix;
      s2_v <= s1_v;

      if (acc && ends && !launch_in) begin
        tail_v <= 1'b1;
      end else if (launch_tail) begin
        tail_v <= 1'b0;
      end

      if (f1_rdy) begin
        f1_v <= launch;
      end
      if (f2_rdy) begin
        f2_v <= f1_v;
      end
      if (f3_rdy) begin
        f3_v <= f2_v;
      end
      if (out_rdy) begin
        out_v <= f3_v;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc && starting) begin
      init_val <= init_now;
    end
    if (acc && !ends) begin
      if (slot_cur == 2'd0) begin
        wbuf0 <= data_word;
      end
      if (slot_cur == 2'd1) begin
        wbuf1 <= data_word;
      end
    end
    if (acc && ends && !launch_in) begin
      tail <= tail_now;
    end

    s1 <= mix_in;
    if (s1_v) begin
      s2 <= mix_lo(s1);
    end
    if (s2_v) begin
      s3 <= mix_hi(s2);
    end

    if (f1_rdy && launch) begin
      f1     <= launch_abc;
      f1_byp <= launch_byp;
    end
    if (f2_rdy && f1_v) begin
      f2     <= f1_byp ? f1 : fin_12(f1);
      f2_byp <= f1_byp;
    end
    if (f3_rdy && f2_v) begin
      f3     <= f2_byp ? f2 : fin_34(f2);
      f3_byp <= f2_byp;
    end
    if (out_rdy && f3_v) begin
      out_r <= f3_byp ? f3 : fin_567(f3);
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_r.c;

endmodule

// ===== tb/word_array_hash_checker.sv =====
// checker for word_array_hash: watches both streams, predicts each hash and compares
// depends on wah_pkg for widths and the initial hash constant
`timescale 1ns / 1ps

module word_array_hash_checker
  import wah_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [InW-1:0]   s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [WordW-1:0] m_tdata,
  output int               mismatches,
  output int               hashes_owed
);

  logic [WordW-1:0]  ha, hb, hc;
  logic [CountW-1:0] words_due;
  logic [1:0]        lane;
  logic [WordW-1:0]  hash_q[$];
  logic [WordW-1:0]  want_hash;

  initial begin
    mismatches  = 0;
    hashes_owed = 0;
  end

  function automatic logic [WordW-1:0] rol(input logic [WordW-1:0] x, input int k);
    return (x << k) | (x >> (WordW - k));
  endfunction

  task automatic mix_triple();
    logic [WordW-1:0] a, b, c;
    a = ha; b = hb; c = hc;
    a -= c; a ^= rol(c, 4);  c += b;
    b -= a; b ^= rol(a, 6);  a += c;
    c -= b; c ^= rol(b, 8);  b += a;
    a -= c; a ^= rol(c, 16); c += b;
    b -= a; b ^= rol(a, 19); a += c;
    c -= b; c ^= rol(b, 4);  b += a;
    ha = a; hb = b; hc = c;
  endtask

  task automatic final_triple();
    logic [WordW-1:0] a, b, c;
    a = ha; b = hb; c = hc;
    c ^= b; c -= rol(b, 14);
    a ^= c; a -= rol(c, 11);
    b ^= a; b -= rol(a, 25);
    c ^= b; c -= rol(b, 16);
    a ^= c; a -= rol(c, 4);
    b ^= a; b -= rol(a, 14);
    c ^= b; c -= rol(b, 24);
    ha = a; hb = b; hc = c;
  endtask

  // one accepted word through the hash; pushes the hash when a message ends
  task automatic absorb_word(input logic [InW-1:0] d);
    logic [WordW-1:0]  w, seed, init;
    logic [CountW-1:0] n;
    w    = d[WordW-1:0];
    n    = d[WordW +: CountW];
    seed = d[WordW+CountW +: WordW];
    if (words_due == 0) begin
      init = HashInit + {14'd0, n, 2'b00} + seed;
      ha   = init;
      hb   = init;
      hc   = init;
      lane = 2'd0;
      // empty message: hash is the initial c, word dropped
      if (n == 0) begin
        hash_q.push_back(init);
        return;
      end
      words_due = n;
    end
    case (lane)
      2'd0: ha += w;
      2'd1: hb += w;
      default: hc += w;
    endcase
    words_due = words_due - CountW'(1);
    if (words_due == 0) begin
      final_triple();
      lane = 2'd0;
      hash_q.push_back(hc);
    end else if (lane >= 2'd2) begin
      mix_triple();
      lane = 2'd0;
    end else begin
      lane = lane + 2'd1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ha = '0; hb = '0; hc = '0;
      words_due = '0;
      lane = 2'd0;
      hash_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (hash_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("hash_value %h arrived with no hash owed", m_tdata);
        end else begin
          want_hash = hash_q.pop_front();
          if (m_tdata !== want_hash) begin
            mismatches++;
            if (mismatches <= 10)
              $display("hash_value: expected %h, got %h", want_hash, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready)
        absorb_word(s_tdata);
    end
    hashes_owed = hash_q.size();
  end

endmodule

// ===== tb/word_array_hash_tb.sv =====
// top of the word_array_hash bench: clock, reset, message stimulus and verdict
// depends on wah_pkg, word_array_hash and word_array_hash_checker
`timescale 1ns / 1ps

module word_array_hash_tb;
  import wah_pkg::*;

  localparam int QuietLimit  = 4000;
  localparam int TailCycles  = 16;
  localparam int RandomWords = 900;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [InW-1:0]   s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [WordW-1:0] m_tdata;
  logic             steady   = 1'b0;
  int               mismatches, hashes_owed;
  int               words_sent   = 0;
  int               quiet_cycles = 0;

  always #2 clk = ~clk;

  word_array_hash dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  word_array_hash_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .hashes_owed(hashes_owed)
  );

  always @(posedge clk) begin
    m_tready <= !rst && (steady || $urandom_range(0, 99) >= 29);
  end

  // no word taken on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CountW-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 90) return CountW'($urandom_range(1, 12));
    if (r < 98) return CountW'($urandom_range(13, 100));
    return CountW'($urandom_range(101, 600));
  endfunction

  task automatic send_word(input logic [WordW-1:0] w, input logic [CountW-1:0] n,
                           input logic [WordW-1:0] seed);
    logic taken;
    while (!steady && $urandom_range(0, 99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {seed, n, w};
    taken = 1'b0;
    // ready is settled by the falling edge, so sample it there
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end
    words_sent++;
  endtask

  // length and seed ride only on the first word; later words carry junk there
  task automatic send_message(input logic [CountW-1:0] n, input logic [WordW-1:0] seed);
    send_word(pick_word(), n, seed);
    for (int i = 1; i < n; i++)
      send_word(pick_word(), CountW'($urandom), $urandom);
  endtask

  task automatic wait_hashes_out();
    do @(negedge clk); while (hashes_owed != 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_word('1, '0, '0);
    send_word('0, '0, '1);
    send_word('1, 16'd1, '1);
    send_word('0, 16'd1, '0);
    for (int n = 2; n <= 5; n++)
      send_message(CountW'(n), $urandom);
    send_message(16'd7, '0);

    // hold the sender off until every hash is out
    s_tvalid <= 1'b0;
    wait_hashes_out();
    @(posedge clk);

    steady <= 1'b1;
    while (words_sent < 175)
      send_message(pick_length(), pick_word());
    steady <= 1'b0;
    while (words_sent < RandomWords + 25)
      send_message(pick_length(), pick_word());

    s_tvalid <= 1'b0;
    wait_hashes_out();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && hashes_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
